// ----- rtl/fmprc_pkg.sv -----
package fmprc_pkg;

    // item opcodes, carried on s_axis_tuser
    localparam logic [1:0] OP_CLASSIFY   = 2'd0;
    localparam logic [1:0] OP_WRITE      = 2'd1;
    localparam logic [1:0] OP_INVALIDATE = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    // rule actions
    localparam logic [2:0] ACT_ACCEPT = 3'd0;
    localparam logic [2:0] ACT_DROP   = 3'd1;
    localparam logic [2:0] ACT_REJECT = 3'd2;
    localparam logic [2:0] ACT_LOG    = 3'd3;
    localparam logic [2:0] ACT_RATE   = 3'd4;

    // rule protocol classes
    localparam logic [1:0] CLS_ALL  = 2'd0;
    localparam logic [1:0] CLS_TCP  = 2'd1;
    localparam logic [1:0] CLS_UDP  = 2'd2;
    localparam logic [1:0] CLS_ICMP = 2'd3;

    // ip protocol numbers
    localparam logic [7:0] IPP_ICMP = 8'd1;
    localparam logic [7:0] IPP_TCP  = 8'd6;
    localparam logic [7:0] IPP_UDP  = 8'd17;

    // connection state flags
    localparam logic [3:0] ST_ESTABLISHED = 4'h1;
    localparam logic [3:0] ST_NEW         = 4'h2;
    localparam logic [3:0] ST_INVALID     = 4'h4;
    localparam logic [3:0] ST_RELATED     = 4'h8;

    // connection tracking update codes
    localparam logic [1:0] TRK_NONE        = 2'd0;
    localparam logic [1:0] TRK_NEW         = 2'd1;
    localparam logic [1:0] TRK_ESTABLISHED = 2'd2;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 24;
    localparam int MAX_SLOTS  = 64;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] smask;
        logic [31:0] dst_ip;
        logic [31:0] dmask;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [3:0]  state_mask;
        logic [1:0]  proto_cls;
        logic [1:0]  direction;
        logic [2:0]  action;
    } rule_t;

endpackage

// ----- rtl/first_match_packet_rule_classifier_top.sv -----
// first-match packet rule classifier
//
// input channel s_axis: one item per handshake. s_axis_tuser holds the opcode
// (classify, write slot, invalidate slot, clear all), s_axis_tdata the header
// or rule fields. output channel m_axis: exactly one result item per input item,
// in order; table operations return an all-zero result.
//
// rules live in one synchronous memory of min(RULES, 64) entries, each read
// into a registered output; valid bits sit in flops. a classify walks the
// slots one per cycle from slot 0 and stops at the first terminating match.
// one item is worked on at a time; s_axis_tready is high while the engine is
// free, also while a finished result waits in the output register.
//
// reset empties the table (all valid bits cleared at once) and drops any
// result in flight. when m_axis_tready is low the result is held and the
// engine stalls in its final step until the output register frees up.
module first_match_packet_rule_classifier_top #(
    parameter int RULES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // rule_slot, src_ip, dst_ip, sport, dport, protocol, direction,
    // smask, dmask, state_flags, rule_action, zero pad
    input  logic [fmprc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // drop_verdict, rule_hit, hit_slot, was_reject, log_hits, track_update,
    // zero pad
    output logic [fmprc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int DEPTH = (RULES < fmprc_pkg::MAX_SLOTS) ? RULES : fmprc_pkg::MAX_SLOTS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam int OUT_DATA_W_L = fmprc_pkg::OUT_DATA_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // input field unpacking
    logic [1:0]  in_opcode;
    logic [5:0]  in_slot;
    logic [31:0] in_src_ip;
    logic [31:0] in_dst_ip;
    logic [15:0] in_sport;
    logic [15:0] in_dport;
    logic [7:0]  in_protocol;
    logic [1:0]  in_direction;
    logic [31:0] in_smask;
    logic [31:0] in_dmask;
    logic [3:0]  in_flags;
    logic [2:0]  in_action;

    assign in_opcode    = s_axis_tuser;
    assign in_slot      = s_axis_tdata[5:0];
    assign in_src_ip    = s_axis_tdata[37:6];
    assign in_dst_ip    = s_axis_tdata[69:38];
    assign in_sport     = s_axis_tdata[85:70];
    assign in_dport     = s_axis_tdata[101:86];
    assign in_protocol  = s_axis_tdata[109:102];
    assign in_direction = s_axis_tdata[111:110];
    assign in_smask     = s_axis_tdata[143:112];
    assign in_dmask     = s_axis_tdata[175:144];
    assign in_flags     = s_axis_tdata[179:176];
    assign in_action    = s_axis_tdata[182:180];

    // control state
    logic [1:0]       state_reg, state_next;
    logic [DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic [IDX_W-1:0] issue_idx_reg, issue_idx_next;
    logic             issue_active_reg, issue_active_next;
    logic             eval_pend_reg, eval_pend_next;
    logic             m_valid_reg, m_valid_next;

    // payload
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;
    logic             eval_vbit_reg, eval_vbit_next;
    logic [31:0]      pkt_sip_reg, pkt_sip_next;
    logic [31:0]      pkt_dip_reg, pkt_dip_next;
    logic [15:0]      pkt_sport_reg, pkt_sport_next;
    logic [15:0]      pkt_dport_reg, pkt_dport_next;
    logic [7:0]       pkt_proto_reg, pkt_proto_next;
    logic [1:0]       pkt_dir_reg, pkt_dir_next;
    logic [3:0]       pkt_flags_reg, pkt_flags_next;
    logic             res_drop_reg, res_drop_next;
    logic             res_hit_reg, res_hit_next;
    logic [5:0]       res_slot_reg, res_slot_next;
    logic             res_rej_reg, res_rej_next;
    logic [6:0]       res_logs_reg, res_logs_next;
    logic [OUT_DATA_W_L-1:0] out_data_reg, out_data_next;

    // rule memory
    fmprc_pkg::rule_t rule_mem [DEPTH];
    fmprc_pkg::rule_t rd_data_reg;
    fmprc_pkg::rule_t wr_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;

    logic             in_fire;
    logic             out_free;
    logic             slot_in_range;
    logic [1:0]       wr_cls;
    logic             ports_on;

    // match evaluation of the entry read last cycle
    logic proto_ok;
    logic src_ok;
    logic dst_ok;
    logic sport_ok;
    logic dport_ok;
    logic flags_ok;
    logic rule_match;
    logic [1:0] track;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign slot_in_range = ({1'b0, in_slot} < 7'(DEPTH));
    assign wr_cls        = (in_protocol > 8'd3) ? fmprc_pkg::CLS_ALL : in_protocol[1:0];
    assign ports_on      = (in_protocol == fmprc_pkg::IPP_TCP) ||
                           (in_protocol == fmprc_pkg::IPP_UDP);

    assign wr_addr = in_slot[IDX_W-1:0];
    assign wr_en   = in_fire && (in_opcode == fmprc_pkg::OP_WRITE) && slot_in_range;
    assign rd_en   = (state_reg == S_SCAN) && issue_active_reg;

    always_comb
    begin
        wr_data.src_ip     = in_src_ip;
        wr_data.smask      = in_smask;
        wr_data.dst_ip     = in_dst_ip;
        wr_data.dmask      = in_dmask;
        wr_data.sport      = in_sport;
        wr_data.dport      = in_dport;
        wr_data.state_mask = in_flags;
        wr_data.proto_cls  = wr_cls;
        wr_data.direction  = in_direction;
        wr_data.action     = in_action;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= rule_mem[issue_idx_reg];
        end
    end

    always_comb
    begin
        unique case (rd_data_reg.proto_cls)
            fmprc_pkg::CLS_TCP:  proto_ok = (pkt_proto_reg == fmprc_pkg::IPP_TCP);
            fmprc_pkg::CLS_UDP:  proto_ok = (pkt_proto_reg == fmprc_pkg::IPP_UDP);
            fmprc_pkg::CLS_ICMP: proto_ok = (pkt_proto_reg == fmprc_pkg::IPP_ICMP);
            default:             proto_ok = 1'b1;
        endcase
    end

    // zero rule address is a wildcard
    assign src_ok   = (rd_data_reg.src_ip == '0) ||
                      (((pkt_sip_reg ^ rd_data_reg.src_ip) & rd_data_reg.smask) == '0);
    assign dst_ok   = (rd_data_reg.dst_ip == '0) ||
                      (((pkt_dip_reg ^ rd_data_reg.dst_ip) & rd_data_reg.dmask) == '0);
    assign sport_ok = (rd_data_reg.sport == '0) || (rd_data_reg.sport == pkt_sport_reg);
    assign dport_ok = (rd_data_reg.dport == '0) || (rd_data_reg.dport == pkt_dport_reg);
    assign flags_ok = (rd_data_reg.state_mask == '0) ||
                      ((rd_data_reg.state_mask & pkt_flags_reg) != '0);
    assign rule_match = eval_vbit_reg && (rd_data_reg.direction == pkt_dir_reg) &&
                        proto_ok && src_ok && dst_ok && sport_ok && dport_ok && flags_ok;

    always_comb
    begin
        if (res_drop_reg)
        begin
            track = fmprc_pkg::TRK_NONE;
        end
        else if ((pkt_flags_reg & fmprc_pkg::ST_NEW) != '0)
        begin
            track = fmprc_pkg::TRK_NEW;
        end
        else if ((pkt_flags_reg & fmprc_pkg::ST_ESTABLISHED) != '0)
        begin
            track = fmprc_pkg::TRK_ESTABLISHED;
        end
        else
        begin
            track = fmprc_pkg::TRK_NONE;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        slot_valid_next   = slot_valid_reg;
        issue_idx_next    = issue_idx_reg;
        issue_active_next = issue_active_reg;
        eval_pend_next    = 1'b0;
        m_valid_next      = m_valid_reg;
        eval_idx_next     = eval_idx_reg;
        eval_vbit_next    = eval_vbit_reg;
        pkt_sip_next      = pkt_sip_reg;
        pkt_dip_next      = pkt_dip_reg;
        pkt_sport_next    = pkt_sport_reg;
        pkt_dport_next    = pkt_dport_reg;
        pkt_proto_next    = pkt_proto_reg;
        pkt_dir_next      = pkt_dir_reg;
        pkt_flags_next    = pkt_flags_reg;
        res_drop_next     = res_drop_reg;
        res_hit_next      = res_hit_reg;
        res_slot_next     = res_slot_reg;
        res_rej_next      = res_rej_reg;
        res_logs_next     = res_logs_reg;
        out_data_next     = out_data_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_drop_next     = 1'b0;
                    res_hit_next      = 1'b0;
                    res_slot_next     = '0;
                    res_rej_next      = 1'b0;
                    res_logs_next     = '0;
                    pkt_sip_next      = in_src_ip;
                    pkt_dip_next      = in_dst_ip;
                    pkt_sport_next    = ports_on ? in_sport : 16'd0;
                    pkt_dport_next    = ports_on ? in_dport : 16'd0;
                    pkt_proto_next    = in_protocol;
                    pkt_dir_next      = in_direction;
                    pkt_flags_next    = (in_opcode == fmprc_pkg::OP_CLASSIFY) ? in_flags : 4'd0;
                    issue_idx_next    = '0;
                    issue_active_next = 1'b1;
                    state_next        = S_FIN;
                    unique case (in_opcode)
                        fmprc_pkg::OP_CLASSIFY:
                        begin
                            state_next = S_SCAN;
                        end
                        fmprc_pkg::OP_WRITE:
                        begin
                            if (slot_in_range)
                            begin
                                slot_valid_next[wr_addr] = 1'b1;
                            end
                        end
                        fmprc_pkg::OP_INVALIDATE:
                        begin
                            if (slot_in_range)
                            begin
                                slot_valid_next[wr_addr] = 1'b0;
                            end
                        end
                        fmprc_pkg::OP_CLEAR:
                        begin
                            slot_valid_next = '0;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue side: one memory read per cycle
                if (issue_active_reg)
                begin
                    eval_pend_next = 1'b1;
                    eval_idx_next  = issue_idx_reg;
                    eval_vbit_next = slot_valid_reg[issue_idx_reg];
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        issue_active_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end
                // evaluate side: entry read in the previous cycle
                if (eval_pend_reg)
                begin
                    if (rule_match && rd_data_reg.action == fmprc_pkg::ACT_LOG)
                    begin
                        if (res_logs_reg != 7'd127)
                        begin
                            res_logs_next = res_logs_reg + 7'd1;
                        end
                        if (eval_idx_reg == LAST_IDX)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else if (rule_match && rd_data_reg.action != fmprc_pkg::ACT_RATE)
                    begin
                        res_hit_next  = 1'b1;
                        res_slot_next = 6'(eval_idx_reg);
                        res_drop_next = (rd_data_reg.action == fmprc_pkg::ACT_DROP) ||
                                        (rd_data_reg.action == fmprc_pkg::ACT_REJECT);
                        res_rej_next  = (rd_data_reg.action == fmprc_pkg::ACT_REJECT);
                        state_next    = S_FIN;
                    end
                    else if (eval_idx_reg == LAST_IDX)
                    begin
                        state_next = S_FIN;
                    end
                end
                if (state_next == S_FIN)
                begin
                    eval_pend_next    = 1'b0;
                    issue_active_next = 1'b0;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    out_data_next = {6'd0, track, res_logs_reg, res_rej_reg, res_slot_reg,
                                     res_hit_reg, res_drop_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slot_valid_reg   <= '0;
            issue_idx_reg    <= '0;
            issue_active_reg <= 1'b0;
            eval_pend_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_valid_reg   <= slot_valid_next;
            issue_idx_reg    <= issue_idx_next;
            issue_active_reg <= issue_active_next;
            eval_pend_reg    <= eval_pend_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg  <= eval_idx_next;
        eval_vbit_reg <= eval_vbit_next;
        pkt_sip_reg   <= pkt_sip_next;
        pkt_dip_reg   <= pkt_dip_next;
        pkt_sport_reg <= pkt_sport_next;
        pkt_dport_reg <= pkt_dport_next;
        pkt_proto_reg <= pkt_proto_next;
        pkt_dir_reg   <= pkt_dir_next;
        pkt_flags_reg <= pkt_flags_next;
        res_drop_reg  <= res_drop_next;
        res_hit_reg   <= res_hit_next;
        res_slot_reg  <= res_slot_next;
        res_rej_reg   <= res_rej_next;
        res_logs_reg  <= res_logs_next;
        out_data_reg  <= out_data_next;
    end

endmodule

// ----- rtl/fmprc_checker.sv -----
module fmprc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fmprc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic       in_fire;
    logic       out_fire;
    logic [1:0] pending_reg, pending_next;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // items accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && !out_fire)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_fire && out_fire)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // one item in the engine plus one in the output register at most
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two items outstanding");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 2'd0)
        else $error("result item without an accepted input item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

    // a drop comes from a deciding rule and never asks for a tracking update
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[8]) |->
        m_axis_tdata[0] && m_axis_tdata[1] && m_axis_tdata[17:16] == fmprc_pkg::TRK_NONE)
        else $error("inconsistent drop verdict fields");

endmodule

bind first_match_packet_rule_classifier_top fmprc_checker u_fmprc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/testbench.sv -----
module testbench;

    localparam logic [1:0] DIR_IN      = 2'd0;
    localparam logic [1:0] DIR_OUT     = 2'd1;
    localparam logic [1:0] DIR_FWD     = 2'd2;
    localparam logic [1:0] DIR_RAW3    = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 80;

    localparam logic [31:0] IP_POOL [8] = '{
        32'h0A000001, 32'h0A000102, 32'hC0A80001, 32'hC0A801FE,
        32'hFFFFFFFF, 32'h00000001, 32'h80000000, 32'h7FFFFFFF
    };
    localparam logic [15:0] PORT_POOL [8] = '{
        16'd80, 16'd443, 16'd53, 16'd22, 16'hFFFF, 16'd1, 16'd8080, 16'd1234
    };

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  slot;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [1:0]  dir;
        logic [31:0] smask;
        logic [31:0] dmask;
        logic [3:0]  flags;
        logic [2:0]  act;
    } acl_item_t;

    typedef struct packed {
        logic       drop;
        logic       hit;
        logic [5:0] slot;
        logic       rej;
        logic [6:0] logs;
        logic [1:0] track;
    } verdict_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [fmprc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                       s_axis_tuser = fmprc_pkg::OP_CLASSIFY;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [fmprc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // shadow copy of the rule table
    fmprc_pkg::rule_t               shadow_rules [fmprc_pkg::MAX_SLOTS] = '{default: '0};
    logic [fmprc_pkg::MAX_SLOTS-1:0] shadow_live = '0;
    verdict_t                       verdicts_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int results_seen  = 0;
    int stall_cycles  = 0;

    first_match_packet_rule_classifier_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic verdict_t acl_apply(input acl_item_t it);
        verdict_t         v;
        fmprc_pkg::rule_t r;
        logic [15:0]      psp;
        logic [15:0]      pdp;
        logic             ok;
        logic             decided;
        int               i;
        v = '0;
        decided = 1'b0;
        case (it.op)
            fmprc_pkg::OP_WRITE:
            begin
                r.src_ip     = it.sip;
                r.smask      = it.smask;
                r.dst_ip     = it.dip;
                r.dmask      = it.dmask;
                r.sport      = it.sport;
                r.dport      = it.dport;
                r.state_mask = it.flags;
                // protocol numbers above the class range fold to "all"
                r.proto_cls  = (it.proto > 8'd3) ? fmprc_pkg::CLS_ALL : it.proto[1:0];
                r.direction  = it.dir;
                r.action     = it.act;
                shadow_rules[it.slot] = r;
                shadow_live[it.slot] = 1'b1;
            end
            fmprc_pkg::OP_INVALIDATE: shadow_live[it.slot] = 1'b0;
            fmprc_pkg::OP_CLEAR:      shadow_live = '0;
            default:
            begin
                psp = it.sport;
                pdp = it.dport;
                if (it.proto != fmprc_pkg::IPP_TCP && it.proto != fmprc_pkg::IPP_UDP)
                begin
                    psp = '0;
                    pdp = '0;
                end
                for (i = 0; i < fmprc_pkg::MAX_SLOTS && !decided; i++)
                begin
                    r = shadow_rules[i];
                    ok = shadow_live[i] && (r.direction == it.dir);
                    case (r.proto_cls)
                        fmprc_pkg::CLS_TCP:  ok = ok && (it.proto == fmprc_pkg::IPP_TCP);
                        fmprc_pkg::CLS_UDP:  ok = ok && (it.proto == fmprc_pkg::IPP_UDP);
                        fmprc_pkg::CLS_ICMP: ok = ok && (it.proto == fmprc_pkg::IPP_ICMP);
                        default:             ok = ok;
                    endcase
                    ok = ok && (r.src_ip == '0 ||
                                (it.sip & r.smask) == (r.src_ip & r.smask));
                    ok = ok && (r.dst_ip == '0 ||
                                (it.dip & r.dmask) == (r.dst_ip & r.dmask));
                    ok = ok && (r.sport == '0 || r.sport == psp);
                    ok = ok && (r.dport == '0 || r.dport == pdp);
                    ok = ok && (r.state_mask == '0 || (r.state_mask & it.flags) != '0);
                    if (ok)
                    begin
                        if (r.action == fmprc_pkg::ACT_LOG)
                        begin
                            if (v.logs != 7'd127)
                                v.logs = v.logs + 7'd1;
                        end
                        else if (r.action != fmprc_pkg::ACT_RATE)
                        begin
                            decided = 1'b1;
                            v.hit   = 1'b1;
                            v.slot  = 6'(i);
                            v.drop  = (r.action == fmprc_pkg::ACT_DROP ||
                                       r.action == fmprc_pkg::ACT_REJECT);
                            v.rej   = (r.action == fmprc_pkg::ACT_REJECT);
                        end
                    end
                end
                if (!v.drop)
                begin
                    if ((it.flags & fmprc_pkg::ST_NEW) != '0)
                        v.track = fmprc_pkg::TRK_NEW;
                    else if ((it.flags & fmprc_pkg::ST_ESTABLISHED) != '0)
                        v.track = fmprc_pkg::TRK_ESTABLISHED;
                    else
                        v.track = fmprc_pkg::TRK_NONE;
                end
            end
        endcase
        return v;
    endfunction

    function automatic acl_item_t mk_rule(input logic [5:0] slot,
                                          input logic [31:0] sip, input logic [31:0] smask,
                                          input logic [31:0] dip, input logic [31:0] dmask,
                                          input logic [15:0] sport, input logic [15:0] dport,
                                          input logic [7:0] proto, input logic [1:0] dir,
                                          input logic [3:0] flags, input logic [2:0] act);
        acl_item_t it;
        it = '0;
        it.op = fmprc_pkg::OP_WRITE;
        it.slot = slot;
        it.sip = sip;
        it.smask = smask;
        it.dip = dip;
        it.dmask = dmask;
        it.sport = sport;
        it.dport = dport;
        it.proto = proto;
        it.dir = dir;
        it.flags = flags;
        it.act = act;
        return it;
    endfunction

    function automatic acl_item_t mk_packet(input logic [31:0] sip, input logic [31:0] dip,
                                            input logic [15:0] sport, input logic [15:0] dport,
                                            input logic [7:0] proto, input logic [1:0] dir,
                                            input logic [3:0] flags);
        acl_item_t it;
        it = '0;
        it.op = fmprc_pkg::OP_CLASSIFY;
        it.sip = sip;
        it.dip = dip;
        it.sport = sport;
        it.dport = dport;
        it.proto = proto;
        it.dir = dir;
        it.flags = flags;
        return it;
    endfunction

    function automatic acl_item_t mk_table_op(input logic [1:0] op, input logic [5:0] slot);
        acl_item_t it;
        it = '0;
        it.op = op;
        it.slot = slot;
        return it;
    endfunction

    function automatic logic [31:0] pick_ip();
        if ($urandom_range(3) == 0)
            return $urandom;
        return IP_POOL[$urandom_range(7)];
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(5))
            0: return 32'hFFFFFFFF;
            1: return 32'hFFFFFF00;
            2: return 32'hFFFF0000;
            3: return 32'hFF000000;
            4: return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return PORT_POOL[$urandom_range(7)];
    endfunction

    function automatic acl_item_t random_noise();
        acl_item_t it;
        it.op    = 2'($urandom_range(3));
        it.slot  = 6'($urandom_range(63));
        it.sip   = $urandom;
        it.dip   = $urandom;
        it.sport = 16'($urandom);
        it.dport = 16'($urandom);
        it.proto = 8'($urandom_range(255));
        it.dir   = 2'($urandom_range(3));
        it.smask = $urandom;
        it.dmask = $urandom;
        it.flags = 4'($urandom_range(15));
        it.act   = 3'($urandom_range(7));
        return it;
    endfunction

    function automatic acl_item_t random_rule();
        acl_item_t it;
        int        pick;
        it = random_noise();
        it.op    = fmprc_pkg::OP_WRITE;
        it.sip   = ($urandom_range(2) == 0) ? 32'h0 : pick_ip();
        it.dip   = ($urandom_range(2) == 0) ? 32'h0 : pick_ip();
        it.smask = pick_mask();
        it.dmask = pick_mask();
        it.sport = ($urandom_range(1) == 0) ? 16'h0 : pick_port();
        it.dport = ($urandom_range(1) == 0) ? 16'h0 : pick_port();
        it.proto = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
        it.flags = ($urandom_range(1) == 0) ? 4'h0 : 4'($urandom_range(15));
        pick = $urandom_range(19);
        // lean toward log and rate rules so scans run deep
        if (pick < 4)
            it.act = fmprc_pkg::ACT_ACCEPT;
        else if (pick < 7)
            it.act = fmprc_pkg::ACT_DROP;
        else if (pick < 9)
            it.act = fmprc_pkg::ACT_REJECT;
        else if (pick < 14)
            it.act = fmprc_pkg::ACT_LOG;
        else if (pick < 18)
            it.act = fmprc_pkg::ACT_RATE;
        else
            it.act = 3'($urandom_range(5, 7));
        return it;
    endfunction

    function automatic acl_item_t random_packet();
        acl_item_t        it;
        fmprc_pkg::rule_t r;
        it = random_noise();
        it.op = fmprc_pkg::OP_CLASSIFY;
        if ($urandom_range(3) != 0)
        begin
            // aim the packet at some rule so it gets past the early checks
            r = shadow_rules[$urandom_range(fmprc_pkg::MAX_SLOTS - 1)];
            it.dir = r.direction;
            it.sip = (r.src_ip == '0) ? pick_ip() :
                     ((r.src_ip & r.smask) | ($urandom & ~r.smask));
            it.dip = (r.dst_ip == '0) ? pick_ip() :
                     ((r.dst_ip & r.dmask) | ($urandom & ~r.dmask));
            case (r.proto_cls)
                fmprc_pkg::CLS_TCP:  it.proto = fmprc_pkg::IPP_TCP;
                fmprc_pkg::CLS_UDP:  it.proto = fmprc_pkg::IPP_UDP;
                fmprc_pkg::CLS_ICMP: it.proto = fmprc_pkg::IPP_ICMP;
                default:
                    case ($urandom_range(3))
                        0: it.proto = fmprc_pkg::IPP_TCP;
                        1: it.proto = fmprc_pkg::IPP_UDP;
                        2: it.proto = fmprc_pkg::IPP_ICMP;
                        default: it.proto = 8'($urandom_range(255));
                    endcase
            endcase
            it.sport = (r.sport == '0) ? pick_port() : r.sport;
            it.dport = (r.dport == '0) ? pick_port() : r.dport;
            if ($urandom_range(7) == 0)
                it.sport = it.sport ^ (16'h1 << $urandom_range(15));
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    endtask

    task automatic send_item(input acl_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {1'b0, it.act, it.flags, it.dmask, it.smask, it.dir, it.proto,
                          it.dport, it.sport, it.dip, it.sip, it.slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        verdicts_due.push_back(acl_apply(it));
    endtask

    task automatic test_empty_table();
        send_item(mk_table_op(fmprc_pkg::OP_CLEAR, 6'd0));
        send_item(mk_packet(32'h0A000001, 32'h0A000002, 16'd1024, 16'd80, fmprc_pkg::IPP_TCP,
                            DIR_IN, fmprc_pkg::ST_NEW));
        send_item(mk_packet(32'h0A000001, 32'h0A000002, 16'd53, 16'd53, fmprc_pkg::IPP_UDP,
                            DIR_OUT, fmprc_pkg::ST_ESTABLISHED));
        send_item(mk_packet('1, '1, '1, '1, 8'hFF, DIR_RAW3, 4'hF));
        send_item(mk_packet('0, '0, '0, '0, 8'h00, DIR_FWD,
                            fmprc_pkg::ST_INVALID | fmprc_pkg::ST_RELATED));
    endtask

    task automatic test_rule_actions();
        send_item(mk_rule(6'd0, '0, '0, '0, '0, '0, '0, 8'(fmprc_pkg::CLS_ALL), DIR_IN,
                          4'h0, fmprc_pkg::ACT_LOG));
        send_item(mk_rule(6'd1, '0, '0, '0, '0, '0, '0, 8'(fmprc_pkg::CLS_ALL), DIR_IN,
                          4'h0, fmprc_pkg::ACT_RATE));
        send_item(mk_rule(6'd2, '0, '0, 32'h0A000000, 32'hFF000000, '0, 16'd80,
                          8'(fmprc_pkg::CLS_TCP), DIR_IN, 4'h0, fmprc_pkg::ACT_REJECT));
        send_item(mk_rule(6'd5, '0, '0, '0, '0, '0, '0, 8'(fmprc_pkg::CLS_ICMP), DIR_IN,
                          4'h0, fmprc_pkg::ACT_DROP));
        send_item(mk_rule(6'd63, '0, '0, '0, '0, '0, '0, 8'(fmprc_pkg::CLS_ALL), DIR_IN,
                          fmprc_pkg::ST_NEW | fmprc_pkg::ST_ESTABLISHED,
                          fmprc_pkg::ACT_ACCEPT));
        send_item(mk_packet(32'hC0A80001, 32'h0A010203, 16'd5000, 16'd80, fmprc_pkg::IPP_TCP,
                            DIR_IN, fmprc_pkg::ST_NEW));
        send_item(mk_packet(32'hC0A80001, 32'h0A010203, 16'd5000, 16'd80, fmprc_pkg::IPP_UDP,
                            DIR_IN, fmprc_pkg::ST_ESTABLISHED));
        // icmp with port bits set: ports must be ignored
        send_item(mk_packet(32'hC0A80001, 32'h0A010203, 16'd80, 16'd80, fmprc_pkg::IPP_ICMP,
                            DIR_IN, fmprc_pkg::ST_NEW));
        send_item(mk_packet(32'hC0A80001, 32'h0B000001, 16'd5000, 16'd80, fmprc_pkg::IPP_TCP,
                            DIR_IN, fmprc_pkg::ST_INVALID));
    endtask

    task automatic test_match_fields();
        // out-of-range protocol class, odd action and direction three in one rule
        send_item(mk_rule(6'd10, 32'hC0A80000, 32'hFFFF0000, '0, '0, '0, '0, 8'd200,
                          DIR_RAW3, fmprc_pkg::ST_INVALID | fmprc_pkg::ST_RELATED, 3'd6));
        send_item(mk_packet(32'hC0A80505, 32'h01020304, 16'd1, 16'd2, fmprc_pkg::IPP_TCP,
                            DIR_RAW3, fmprc_pkg::ST_INVALID));
        send_item(mk_packet(32'hC0A80505, 32'h01020304, 16'd1, 16'd2, fmprc_pkg::IPP_TCP,
                            DIR_RAW3, fmprc_pkg::ST_NEW));
        send_item(mk_rule(6'd11, '0, '0, '0, '0, 16'd1234, '0, 8'(fmprc_pkg::CLS_UDP),
                          DIR_RAW3, 4'h0, fmprc_pkg::ACT_DROP));
        send_item(mk_packet(32'hC0A80505, 32'h01020304, 16'd1234, 16'd9, fmprc_pkg::IPP_UDP,
                            DIR_RAW3, fmprc_pkg::ST_ESTABLISHED));
        send_item(mk_rule(6'd12, '0, '0, '0, '0, 16'd7, '0, 8'(fmprc_pkg::CLS_ALL), DIR_FWD,
                          4'h0, fmprc_pkg::ACT_ACCEPT));
        send_item(mk_packet(32'h01010101, 32'h02020202, 16'd7, 16'd7, fmprc_pkg::IPP_ICMP,
                            DIR_FWD, fmprc_pkg::ST_NEW));
    endtask

    task automatic test_table_ops();
        send_item(mk_table_op(fmprc_pkg::OP_INVALIDATE, 6'd2));
        send_item(mk_packet(32'hC0A80001, 32'h0A010203, 16'd5000, 16'd80, fmprc_pkg::IPP_TCP,
                            DIR_IN, fmprc_pkg::ST_NEW));
        send_item(mk_table_op(fmprc_pkg::OP_CLEAR, 6'd63));
        send_item(mk_packet(32'hC0A80001, 32'h0A010203, 16'd5000, 16'd80, fmprc_pkg::IPP_TCP,
                            DIR_IN, fmprc_pkg::ST_NEW));
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        acl_item_t it;
        int        pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            pick = $urandom_range(199);
            if (pick < 110)
                it = random_packet();
            else if (pick < 175)
                it = random_rule();
            else
            begin
                it = random_noise();
                it.op = (pick < 195) ? fmprc_pkg::OP_INVALIDATE : fmprc_pkg::OP_CLEAR;
            end
            send_item(it);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        repeat (3)
            send_item(random_rule());
        repeat (7)
            send_item(random_packet());
    endtask

    // result side: random idling plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch("result with nothing pending", int'(m_axis_tdata), 0);
            else
            begin
                want = verdicts_due.pop_front();
                if (m_axis_tdata[0] !== want.drop)
                    report_mismatch("drop_verdict", m_axis_tdata[0], want.drop);
                if (m_axis_tdata[1] !== want.hit)
                    report_mismatch("rule_hit", m_axis_tdata[1], want.hit);
                if (m_axis_tdata[7:2] !== want.slot)
                    report_mismatch("hit_slot", m_axis_tdata[7:2], want.slot);
                if (m_axis_tdata[8] !== want.rej)
                    report_mismatch("was_reject", m_axis_tdata[8], want.rej);
                if (m_axis_tdata[15:9] !== want.logs)
                    report_mismatch("log_hits", m_axis_tdata[15:9], want.logs);
                if (m_axis_tdata[17:16] !== want.track)
                    report_mismatch("track_update", m_axis_tdata[17:16], want.track);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("** first_match_packet_rule_classifier_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 63;
        test_empty_table();
        test_rule_actions();
        test_match_fields();
        test_table_ops();
        test_random_traffic(560, 13, 63);
        test_backpressure();
        test_random_traffic(560, 63, 13);
        test_random_traffic(560, 0, 0);
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** first_match_packet_rule_classifier_top: PASSED **");
        else
            $display("** first_match_packet_rule_classifier_top: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/fmprc_pkg.sv
rtl/first_match_packet_rule_classifier_top.sv
rtl/fmprc_checker.sv
test/testbench.sv
